>>> rtl/core/tcbm_pkg.sv
// Shared types, constants and helpers for the connection best-match lookup.
// No dependencies; imported by every module of the block.
package tcbm_pkg;

	localparam int ADDR_W          = 32;
	localparam int PORT_W          = 16;
	localparam int MIDX_W          = 6;
	localparam int SCORE_W         = 5;
	localparam int TBL_ENTRIES_DEF = 64;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	localparam logic [SCORE_W-1:0] FULL_SCORE = 5'd22;
	localparam logic [SCORE_W-1:0] COST_FADDR = 5'd8;
	localparam logic [SCORE_W-1:0] COST_FPORT = 5'd8;
	localparam logic [SCORE_W-1:0] COST_LNET  = 5'd1;
	localparam logic [SCORE_W-1:0] COST_LADDR = 5'd2;
	localparam logic [SCORE_W-1:0] COST_LPORT = 5'd4;

	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [PORT_W-1:0]  port_t;
	typedef logic [SCORE_W-1:0] score_t;
	typedef logic [MIDX_W-1:0]  midx_t;

	// one connection, also used as the lookup key
	typedef struct packed {
		addr_t faddr;
		port_t fport;
		addr_t laddr;
		port_t lport;
	} entry_t;

	// table port controls from the sequencer
	typedef struct packed {
		logic ent_we;
		logic act_we;
		logic act_wd;
		logic re;
	} tbl_ctl_t;

	function automatic addr_t classful_net(input addr_t a);
		addr_t net;
		if (a[31] == 1'b0) begin
			net = a & 32'hFF00_0000;
		end else if (a[31:30] == 2'b10) begin
			net = a & 32'hFFFF_0000;
		end else if (a[31:29] == 3'b110) begin
			net = a & 32'hFFFF_FF00;
		end else begin
			net = a;
		end
		return net;
	endfunction

endpackage

>>> rtl/core/tcbm_table.sv
// Connection table storage: active-mark memory and entry-field memory.
// One write port and one registered read port each. Depends on tcbm_pkg.
module tcbm_table import tcbm_pkg::*; #(
	parameter int TABLE_ENTRIES = TBL_ENTRIES_DEF,
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
	input  logic             clk,
	input  tbl_ctl_t         ctl,
	input  logic [IDX_W-1:0] wr_addr,
	input  entry_t           wr_entry,
	input  logic [IDX_W-1:0] rd_addr,
	output logic             rd_active,
	output entry_t           rd_entry
);

	logic   act_mem [TABLE_ENTRIES];
	entry_t ent_mem [TABLE_ENTRIES];

	always_ff @(posedge clk) begin
		if (ctl.act_we) begin
			act_mem[wr_addr] <= ctl.act_wd;
		end
		if (ctl.re) begin
			rd_active <= act_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ent_we) begin
			ent_mem[wr_addr] <= wr_entry;
		end
		if (ctl.re) begin
			rd_entry <= ent_mem[rd_addr];
		end
	end

endmodule

>>> rtl/core/tcbm_score.sv
// Scores one table entry against the lookup key with wildcard costs.
// Pure combinational. Depends on tcbm_pkg.
module tcbm_score import tcbm_pkg::*; (
	input  entry_t key,
	input  entry_t ent,
	input  logic   active,
	input  port_t  wildcard_port,
	output logic   hit,
	output score_t score
);

	addr_t  net;
	logic   reject;
	score_t cost;

	always_comb begin
		net    = classful_net(key.laddr);
		reject = 1'b0;
		cost   = '0;
		if (ent.faddr != key.faddr) begin
			if (ent.faddr != '0) reject = 1'b1;
			cost = cost + COST_FADDR;
		end
		if (ent.fport != key.fport) begin
			if (ent.fport != wildcard_port) reject = 1'b1;
			cost = cost + COST_FPORT;
		end
		// network-part test wins over the zero wildcard
		if (ent.laddr != key.laddr) begin
			if (ent.laddr == net) begin
				cost = cost + COST_LNET;
			end else if (ent.laddr != '0) begin
				reject = 1'b1;
			end else begin
				cost = cost + COST_LADDR;
			end
		end
		if (ent.lport != key.lport) begin
			if (ent.lport != wildcard_port) reject = 1'b1;
			cost = cost + COST_LPORT;
		end
		hit   = active && !reject;
		score = FULL_SCORE - cost;
	end

endmodule

>>> rtl/core/tcbm_ctrl.sv
// Sequencer: clearing pass, write items, lookup scan with best-match tracking.
// Drives the table ports and the result strobe. Depends on tcbm_pkg.
module tcbm_ctrl import tcbm_pkg::*; #(
	parameter int TABLE_ENTRIES = TBL_ENTRIES_DEF,
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             cmd,
	input  logic [MIDX_W-1:0] entry_index,
	input  logic             entry_active,
	input  entry_t           key_in,
	input  logic             hit,
	input  score_t           score,
	output logic             busy,
	output entry_t           key_q,
	output tbl_ctl_t         tbl_ctl,
	output logic [IDX_W-1:0] wr_addr,
	output logic [IDX_W-1:0] rd_addr,
	output logic             done,
	output logic             found,
	output midx_t            match_index,
	output score_t           match_score
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN
	} state_t;

	localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_ENTRIES - 1);

	state_t           state_q;
	logic [IDX_W-1:0] ptr_q;
	logic             issue_q;
	logic             valid_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             best_found_q;
	logic [IDX_W-1:0] best_idx_q;
	score_t           best_score_q;
	logic             done_q;
	logic             found_q;
	midx_t            match_index_q;
	score_t           match_score_q;

	logic             accept;
	logic             in_range;
	logic             wr_en;
	logic             full;
	logic             take;
	logic             finish;
	logic             nb_found;
	logic [IDX_W-1:0] nb_idx;
	score_t           nb_score;

	assign accept   = start && (state_q == ST_IDLE);
	assign in_range = 32'(entry_index) < 32'(TABLE_ENTRIES);
	assign wr_en    = accept && (cmd == CMD_WRITE) && in_range;

	always_comb begin
		tbl_ctl.ent_we = wr_en;
		tbl_ctl.act_we = wr_en || (state_q == ST_CLEAR);
		tbl_ctl.act_wd = (state_q == ST_CLEAR) ? 1'b0 : entry_active;
		tbl_ctl.re     = (state_q == ST_SCAN) && issue_q;
		wr_addr        = (state_q == ST_CLEAR) ? ptr_q : IDX_W'(entry_index);
		rd_addr        = ptr_q;
	end

	// best-so-far update for the entry read last cycle; a later tie wins
	assign full   = hit && (score == FULL_SCORE);
	assign take   = (state_q == ST_SCAN) && valid_s1 && hit &&
		(full || !best_found_q || (score >= best_score_q));
	assign finish = (state_q == ST_SCAN) && valid_s1 && (full || (idx_s1 == LAST));

	always_comb begin
		nb_found = best_found_q;
		nb_idx   = best_idx_q;
		nb_score = best_score_q;
		if (take) begin
			nb_found = 1'b1;
			nb_idx   = idx_s1;
			nb_score = score;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			ptr_q         <= '0;
			issue_q       <= 1'b0;
			valid_s1      <= 1'b0;
			best_found_q  <= 1'b0;
			best_idx_q    <= '0;
			best_score_q  <= '0;
			done_q        <= 1'b0;
			found_q       <= 1'b0;
			match_index_q <= '0;
			match_score_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					if (ptr_q == LAST) begin
						ptr_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (cmd == CMD_LOOKUP) begin
							state_q      <= ST_SCAN;
							ptr_q        <= '0;
							issue_q      <= 1'b1;
							valid_s1     <= 1'b0;
							best_found_q <= 1'b0;
							best_idx_q   <= '0;
							best_score_q <= '0;
						end else begin
							done_q        <= 1'b1;
							found_q       <= 1'b0;
							match_index_q <= '0;
							match_score_q <= '0;
						end
					end
				end
				ST_SCAN: begin
					best_found_q <= nb_found;
					best_idx_q   <= nb_idx;
					best_score_q <= nb_score;
					if (finish) begin
						// drop the read still in flight after an exact match
						state_q       <= ST_IDLE;
						issue_q       <= 1'b0;
						valid_s1      <= 1'b0;
						done_q        <= 1'b1;
						found_q       <= nb_found;
						match_index_q <= MIDX_W'(nb_idx);
						match_score_q <= nb_score;
					end else begin
						valid_s1 <= issue_q;
						if (issue_q) begin
							if (ptr_q == LAST) begin
								issue_q <= 1'b0;
							end else begin
								ptr_q <= ptr_q + 1'b1;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (cmd == CMD_LOOKUP)) begin
			key_q <= key_in;
		end
		if ((state_q == ST_SCAN) && issue_q) begin
			idx_s1 <= ptr_q;
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign found       = found_q;
	assign match_index = match_index_q;
	assign match_score = match_score_q;

endmodule

>>> rtl/core/tcp_connection_best_match_lookup_top.sv
// Top level of the connection best-match lookup: table, scorer, sequencer
// and the wildcard_port register. Depends on tcbm_pkg and the tcbm_* modules.
//
// Usage:
//   Command channel: an item is taken at a clock edge with start high and
//   busy low. cmd selects a table write (entry_index, entry_active and the
//   four address/port fields) or a lookup (the four fields are the key).
//   Result channel: done is high for exactly one cycle per item, with
//   found, match_index and match_score valid in that cycle. The receiver
//   cannot stall; every result must be taken when shown.
//   Config channel: cfg_data is written into wildcard_port on a beat with
//   cfg_valid and cfg_ready; cfg_ready is always high. Write it only idle.
// Timing:
//   A write is stored at its accept edge; its result shows in the next
//   cycle and a new item can be taken in that same cycle (one per cycle).
//   A lookup reads one entry per cycle from the table memory and scores it
//   in the next cycle; the result is registered from the last entry's score
//   or from the first exact match, which ends the scan early. busy stays
//   high during the scan, whose length is set by the single read port.
// Reset: arst_n clears control state and starts a clearing pass over all
//   TABLE_ENTRIES active marks, writing them to zero; busy is high meanwhile.
module tcp_connection_best_match_lookup_top import tcbm_pkg::*; #(
	parameter int TABLE_ENTRIES = TBL_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              cmd,
	input  logic [MIDX_W-1:0] entry_index,
	input  logic              entry_active,
	input  addr_t             foreign_addr,
	input  port_t             foreign_port,
	input  addr_t             local_addr,
	input  port_t             local_port,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  port_t             cfg_data,
	output logic              done,
	output logic              found,
	output midx_t             match_index,
	output score_t            match_score
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	port_t            wildcard_port_q;
	entry_t           key_in;
	entry_t           key_q;
	tbl_ctl_t         tbl_ctl;
	logic [IDX_W-1:0] wr_addr;
	logic [IDX_W-1:0] rd_addr;
	logic             rd_active;
	entry_t           rd_entry;
	logic             hit;
	score_t           score;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wildcard_port_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			wildcard_port_q <= cfg_data;
		end
	end

	assign key_in = '{faddr: foreign_addr, fport: foreign_port,
		laddr: local_addr, lport: local_port};

	tcbm_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_table (
		.clk       (clk),
		.ctl       (tbl_ctl),
		.wr_addr   (wr_addr),
		.wr_entry  (key_in),
		.rd_addr   (rd_addr),
		.rd_active (rd_active),
		.rd_entry  (rd_entry)
	);

	tcbm_score u_score (
		.key           (key_q),
		.ent           (rd_entry),
		.active        (rd_active),
		.wildcard_port (wildcard_port_q),
		.hit           (hit),
		.score         (score)
	);

	tcbm_ctrl #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.cmd          (cmd),
		.entry_index  (entry_index),
		.entry_active (entry_active),
		.key_in       (key_in),
		.hit          (hit),
		.score        (score),
		.busy         (busy),
		.key_q        (key_q),
		.tbl_ctl      (tbl_ctl),
		.wr_addr      (wr_addr),
		.rd_addr      (rd_addr),
		.done         (done),
		.found        (found),
		.match_index  (match_index),
		.match_score  (match_score)
	);

endmodule

>>> rtl/core/tcbm_checker.sv
// Port-level checks for the connection best-match lookup, bound to the top.
// Depends on tcbm_pkg and tcp_connection_best_match_lookup_top.
module tcbm_checker import tcbm_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   start,
	input logic   busy,
	input logic   cmd,
	input logic   done,
	input logic   found,
	input midx_t  match_index,
	input score_t match_score
);

	// results only show once the sequencer has let go
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_write_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd == CMD_WRITE)) |=> (done && !found))
		else $error("write item did not return an empty result next cycle");

	a_lookup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd == CMD_LOOKUP)) |=> (busy && !done))
		else $error("lookup did not start a scan");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !found) |-> ((match_index == '0) && (match_score == '0)))
		else $error("miss result carries nonzero index or score");

	a_score_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found) |-> (match_score <= FULL_SCORE))
		else $error("score above full match");

endmodule

bind tcp_connection_best_match_lookup_top tcbm_checker u_tcbm_checker (.*);

>>> verif/tcp_connection_best_match_lookup_top_test.sv
`timescale 1ns / 100ps
// Self-checking bench for tcp_connection_best_match_lookup_top: table writes and lookups,
// each done beat checked against a local copy of the table and a best-match scorer.
// Depends on tcbm_pkg and the block's RTL only.
module tcp_connection_best_match_lookup_top_test;
	import tcbm_pkg::*;

	localparam int N_SLOTS     = TBL_ENTRIES_DEF;
	localparam int SCAN_CYCLES = N_SLOTS + 2;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		logic   op;
		midx_t  slot;
		logic   live;
		entry_t conn;
	} conn_cmd_t;

	typedef struct {
		logic   hit;
		midx_t  slot;
		score_t score;
	} match_t;

	logic   clk          = 1'b0;
	logic   arst_n       = 1'b0;
	logic   start        = 1'b0;
	logic   busy;
	logic   cmd          = CMD_WRITE;
	midx_t  entry_index  = '0;
	logic   entry_active = 1'b0;
	addr_t  foreign_addr = '0;
	port_t  foreign_port = '0;
	addr_t  local_addr   = '0;
	port_t  local_port   = '0;
	logic   cfg_valid    = 1'b0;
	logic   cfg_ready;
	port_t  cfg_data     = '0;
	logic   done;
	logic   found;
	midx_t  match_index;
	score_t match_score;

	// local copy of the block state
	entry_t conn_tbl [N_SLOTS];
	logic   conn_live [N_SLOTS];
	port_t  wc_port = '0;

	match_t pending_results [$];
	addr_t  addr_pool [8];
	port_t  port_pool [6];
	bit     idling_on = 1'b1;
	int     errors = 0;
	int     cycles = 0;
	int     n_writes = 0;
	int     n_lookups = 0;
	int     n_hits = 0;
	int     n_exact = 0;
	int     n_settings = 0;

	tcp_connection_best_match_lookup_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.entry_index  (entry_index),
		.entry_active (entry_active),
		.foreign_addr (foreign_addr),
		.foreign_port (foreign_port),
		.local_addr   (local_addr),
		.local_port   (local_port),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.done         (done),
		.found        (found),
		.match_index  (match_index),
		.match_score  (match_score)
	);

	always #1 clk = ~clk;

	function automatic addr_t net_part(input addr_t a);
		addr_t mask;
		casez (a[31:29])
			3'b0??: mask = 32'hFF00_0000;
			3'b10?: mask = 32'hFFFF_0000;
			3'b110: mask = 32'hFFFF_FF00;
			default: mask = '1;
		endcase
		return a & mask;
	endfunction

	function automatic match_t best_match_for(input entry_t key);
		match_t best;
		score_t s;
		addr_t  knet;
		bit     ok;
		best = '{hit: 1'b0, slot: '0, score: '0};
		knet = net_part(key.laddr);
		for (int i = 0; i < N_SLOTS; i++) begin
			if (!conn_live[i]) begin
				continue;
			end
			s = FULL_SCORE;
			ok = 1'b1;
			if (conn_tbl[i].faddr != key.faddr) begin
				if (conn_tbl[i].faddr == '0) s -= COST_FADDR;
				else ok = 1'b0;
			end
			if (conn_tbl[i].fport != key.fport) begin
				if (conn_tbl[i].fport == wc_port) s -= COST_FPORT;
				else ok = 1'b0;
			end
			// network-part test wins over the wildcard test
			if (conn_tbl[i].laddr != key.laddr) begin
				if (conn_tbl[i].laddr == knet) s -= COST_LNET;
				else if (conn_tbl[i].laddr == '0) s -= COST_LADDR;
				else ok = 1'b0;
			end
			if (conn_tbl[i].lport != key.lport) begin
				if (conn_tbl[i].lport == wc_port) s -= COST_LPORT;
				else ok = 1'b0;
			end
			if (ok) begin
				if (s == FULL_SCORE) begin
					best = '{hit: 1'b1, slot: midx_t'(i), score: s};
					break;
				end
				// later tie replaces earlier
				if (!best.hit || s >= best.score) begin
					best = '{hit: 1'b1, slot: midx_t'(i), score: s};
				end
			end
		end
		return best;
	endfunction

	function automatic conn_cmd_t conn_cmd(input logic op, input int slot, input logic live,
			input addr_t fa, input port_t fp, input addr_t la, input port_t lp);
		conn_cmd_t c;
		c.op = op;
		c.slot = midx_t'(slot);
		c.live = live;
		c.conn = '{faddr: fa, fport: fp, laddr: la, lport: lp};
		return c;
	endfunction

	function automatic void fill_pools();
		addr_t a;
		for (int i = 0; i < 8; i++) begin
			a = $urandom;
			case (i % 4)
				0: a[31] = 1'b0;
				1: a[31:30] = 2'b10;
				2: a[31:29] = 3'b110;
				default: a[31:29] = 3'b111;
			endcase
			addr_pool[i] = a;
		end
		foreach (port_pool[i]) begin
			port_pool[i] = port_t'($urandom_range(16'hFFFF));
		end
	endfunction

	function automatic addr_t pick_addr();
		int r;
		r = $urandom_range(99);
		if (r < 20) return '0;
		if (r < 90) return addr_pool[$urandom_range(7)];
		return addr_t'($urandom);
	endfunction

	function automatic addr_t pick_laddr();
		int r;
		r = $urandom_range(99);
		if (r < 15) return '0;
		if (r < 30) return net_part(addr_pool[$urandom_range(7)]);
		if (r < 90) return addr_pool[$urandom_range(7)];
		return addr_t'($urandom);
	endfunction

	function automatic port_t pick_port();
		int r;
		r = $urandom_range(99);
		if (r < 20) return wc_port;
		if (r < 90) return port_pool[$urandom_range(5)];
		return port_t'($urandom);
	endfunction

	// mostly lookups built from live entries so the scan gets past the reject paths
	function automatic conn_cmd_t rand_cmd();
		conn_cmd_t c;
		entry_t    e;
		int        r;
		midx_t     s;
		r = $urandom_range(99);
		c.slot = midx_t'($urandom_range(N_SLOTS - 1));
		c.live = ($urandom_range(3) != 0);
		if (r < 5) begin
			c.op = 1'($urandom_range(1));
			c.live = 1'($urandom_range(1));
			c.conn = {$urandom, $urandom, $urandom};
		end else if (r < 40) begin
			c.op = CMD_WRITE;
			c.conn = '{faddr: pick_addr(), fport: pick_port(), laddr: pick_laddr(),
				lport: pick_port()};
		end else begin
			c.op = CMD_LOOKUP;
			if ($urandom_range(9) < 7) begin
				s = midx_t'($urandom_range(N_SLOTS - 1));
				for (int t = 0; t < 8 && !conn_live[s]; t++) begin
					s = midx_t'($urandom_range(N_SLOTS - 1));
				end
				e = conn_tbl[s];
				c.conn.faddr = (e.faddr == '0) ? addr_pool[$urandom_range(7)] : e.faddr;
				c.conn.fport = (e.fport == wc_port) ? port_pool[$urandom_range(5)] : e.fport;
				c.conn.laddr = ($urandom_range(1) == 0) ? e.laddr : addr_pool[$urandom_range(7)];
				c.conn.lport = (e.lport == wc_port) ? port_pool[$urandom_range(5)] : e.lport;
				if ($urandom_range(6) == 0) begin
					case ($urandom_range(3))
						0: c.conn.faddr = addr_t'($urandom);
						1: c.conn.fport = port_t'($urandom);
						2: c.conn.laddr = addr_t'($urandom);
						default: c.conn.lport = port_t'($urandom);
					endcase
				end
			end else begin
				c.conn = '{faddr: pick_addr(), fport: pick_port(), laddr: pick_addr(),
					lport: pick_port()};
			end
		end
		return c;
	endfunction

	function automatic void flag_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		errors++;
		if (errors <= MAX_REPORTS) begin
			$display("[%0t] mismatch on %s: expected %0h, got %0h", $time, what, want, got);
		end
	endfunction

	// drive at the falling edge; start stays high across back-to-back items
	task automatic issue_cmd(input conn_cmd_t c);
		int     gap;
		match_t want;
		@(negedge clk);
		if (idling_on && $urandom_range(99) < 26) begin
			gap = ($urandom_range(7) == 0) ? $urandom_range(80, 1) : $urandom_range(4, 1);
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd = c.op;
		entry_index = c.slot;
		entry_active = c.live;
		foreign_addr = c.conn.faddr;
		foreign_port = c.conn.fport;
		local_addr = c.conn.laddr;
		local_port = c.conn.lport;
		start = 1'b1;
		do @(posedge clk); while (busy);
		want = '{hit: 1'b0, slot: '0, score: '0};
		if (c.op == CMD_WRITE) begin
			conn_tbl[c.slot] = c.conn;
			conn_live[c.slot] = c.live;
			n_writes++;
		end else begin
			want = best_match_for(c.conn);
			n_lookups++;
			if (want.hit) n_hits++;
			if (want.hit && want.score == FULL_SCORE) n_exact++;
		end
		pending_results.push_back(want);
	endtask

	task automatic drain_results();
		@(negedge clk);
		start = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic set_wildcard_port(input port_t v);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		wc_port = v;
		n_settings++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// every slot gets written once, inactive, so no lookup ever scans unwritten fields
	task automatic test_table_setup();
		for (int i = 0; i < N_SLOTS; i++) begin
			issue_cmd(conn_cmd(CMD_WRITE, i, 1'b0, addr_t'($urandom), port_t'($urandom),
				addr_t'($urandom), port_t'($urandom)));
		end
		drain_results();
	endtask

	// runs with the wildcard port at 0
	task automatic test_directed_matching();
		// all-ones entry at slot 0: exact hit, then a port miss
		issue_cmd(conn_cmd(CMD_WRITE, 0, 1'b1, '1, '1, '1, '1));
		issue_cmd(conn_cmd(CMD_LOOKUP, 0, 1'b0, '1, '1, '1, '1));
		issue_cmd(conn_cmd(CMD_LOOKUP, 0, 1'b0, '1, 16'h0001, '1, '1));
		// all-wildcard entry at slot 63 scores zero, or one when the key net is zero
		issue_cmd(conn_cmd(CMD_WRITE, 63, 1'b1, '0, '0, '0, '0));
		issue_cmd(conn_cmd(CMD_LOOKUP, 0, 1'b0, 32'h0102_0304, 16'h1111, 32'h8A0B_0C0D,
			16'h2222));
		issue_cmd(conn_cmd(CMD_LOOKUP, 0, 1'b0, 32'h0102_0304, 16'h1111, 32'h00AB_CDEF,
			16'h2222));
		// classful network part, one slot per class
		issue_cmd(conn_cmd(CMD_WRITE, 10, 1'b1, 32'h0A00_0001, 16'h0050, 32'h0A00_0000,
			16'h1F90));
		issue_cmd(conn_cmd(CMD_LOOKUP, 0, 1'b0, 32'h0A00_0001, 16'h0050, 32'h0A11_2233,
			16'h1F90));
		issue_cmd(conn_cmd(CMD_WRITE, 11, 1'b1, 32'h0A00_0001, 16'h0050, 32'h8A0B_0000,
			16'h1F90));
		issue_cmd(conn_cmd(CMD_LOOKUP, 0, 1'b0, 32'h0A00_0001, 16'h0050, 32'h8A0B_1234,
			16'h1F90));
		issue_cmd(conn_cmd(CMD_WRITE, 12, 1'b1, 32'h0A00_0001, 16'h0050, 32'hC0A8_0100,
			16'h1F90));
		issue_cmd(conn_cmd(CMD_LOOKUP, 0, 1'b0, 32'h0A00_0001, 16'h0050, 32'hC0A8_0142,
			16'h1F90));
		issue_cmd(conn_cmd(CMD_WRITE, 13, 1'b1, 32'h0A00_0001, 16'h0050, 32'hE000_0000,
			16'h1F90));
		issue_cmd(conn_cmd(CMD_LOOKUP, 0, 1'b0, 32'h0A00_0001, 16'h0050, 32'hE000_0001,
			16'h1F90));
		// equal partial scores: the later slot wins
		issue_cmd(conn_cmd(CMD_WRITE, 20, 1'b1, '0, 16'h1234, 32'h0B00_0005, 16'h0050));
		issue_cmd(conn_cmd(CMD_WRITE, 30, 1'b1, '0, 16'h1234, 32'h0B00_0005, 16'h0050));
		issue_cmd(conn_cmd(CMD_LOOKUP, 0, 1'b0, 32'h0102_0304, 16'h1234, 32'h0B00_0005,
			16'h0050));
		// two exact entries: the scan stops at the first
		issue_cmd(conn_cmd(CMD_WRITE, 40, 1'b1, 32'hC000_0201, 16'hD431, 32'h0A0A_0A0A,
			16'h0016));
		issue_cmd(conn_cmd(CMD_WRITE, 50, 1'b1, 32'hC000_0201, 16'hD431, 32'h0A0A_0A0A,
			16'h0016));
		issue_cmd(conn_cmd(CMD_LOOKUP, 0, 1'b0, 32'hC000_0201, 16'hD431, 32'h0A0A_0A0A,
			16'h0016));
		// closed entry is skipped even on an exact key
		issue_cmd(conn_cmd(CMD_WRITE, 45, 1'b0, 32'h1122_3344, 16'h5555, 32'h6677_8899,
			16'hAAAA));
		issue_cmd(conn_cmd(CMD_LOOKUP, 0, 1'b0, 32'h1122_3344, 16'h5555, 32'h6677_8899,
			16'hAAAA));
		issue_cmd(conn_cmd(CMD_WRITE, 63, 1'b0, '0, '0, '0, '0));
		issue_cmd(conn_cmd(CMD_LOOKUP, 0, 1'b0, 32'h1122_3344, 16'h5555, 32'h6677_8899,
			16'hAAAA));
		drain_results();
	endtask

	task automatic test_random_phase(input port_t wc, input int n_items, input bit idle);
		drain_results();
		set_wildcard_port(wc);
		idling_on = idle;
		repeat (n_items) issue_cmd(rand_cmd());
		drain_results();
	endtask

	// one result beat per done cycle, compared with the oldest prediction
	always @(posedge clk) begin
		match_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				flag_mismatch("unexpected result beat", 32'd0, 32'd1);
			end else begin
				want = pending_results.pop_front();
				if (found !== want.hit) flag_mismatch("found", 32'(want.hit), 32'(found));
				if (match_index !== want.slot) flag_mismatch("match_index", 32'(want.slot),
					32'(match_index));
				if (match_score !== want.score) flag_mismatch("match_score",
					32'(want.score), 32'(match_score));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_results.size());
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		foreach (conn_live[i]) begin
			conn_live[i] = 1'b0;
			conn_tbl[i] = '0;
		end
		fill_pools();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// let the clearing pass over the active marks finish
		@(posedge clk);
		@(negedge clk);
		while (busy) @(negedge clk);
		set_wildcard_port(16'h0000);
		test_table_setup();
		test_directed_matching();
		test_random_phase(16'hFFFF, 140, 1'b1);
		test_random_phase(port_t'($urandom), 140, 1'b0);
		test_random_phase(16'h0000, 140, 1'b1);
		test_random_phase(port_t'($urandom), 140, 1'b1);
		repeat (SCAN_CYCLES) @(posedge clk);
		$display("Covered %0d table writes and %0d lookups (%0d matched, %0d exact)",
			n_writes, n_lookups, n_hits, n_exact);
		$display("across %0d wildcard port settings; %0d mismatches", n_settings, errors);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
